// ----- sv/xbmt_pkg.sv -----
package xbmt_pkg;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned DATA_W = 16;

  localparam int unsigned RAM_BYTES = 131072;
  localparam int unsigned ROM_AW = 13;
  localparam int unsigned ROM_BYTES = 1 << ROM_AW;
  localparam int unsigned VIDEO_AW = 12;
  localparam int unsigned VIDEO_BYTES = 1 << VIDEO_AW;

  localparam int unsigned RAM_WORDS = RAM_BYTES / 2;
  localparam int unsigned RAM_IW = $clog2(RAM_WORDS);
  localparam int unsigned ROM_IW = ROM_AW - 1;
  localparam int unsigned VID_IW = VIDEO_AW - 1;
  localparam int unsigned IDX_W0 = (RAM_IW > ROM_IW) ? RAM_IW : ROM_IW;
  localparam int unsigned IDX_W = (IDX_W0 > VID_IW) ? IDX_W0 : VID_IW;

  localparam logic [ADDR_W-1:0] RAM_LIMIT = ADDR_W'(RAM_BYTES);
  localparam logic [ADDR_W:0] MAP_TOP = 21'h100000;
  localparam logic [ADDR_W-1:0] ROM_BASE = ADDR_W'(MAP_TOP - (ADDR_W+1)'(ROM_BYTES));
  localparam logic [ADDR_W-1:0] ROM_LIMIT = ADDR_W'(ROM_BYTES);
  localparam logic [ADDR_W-1:0] VIDEO_BASE = 20'hB0000;
  localparam logic [ADDR_W-1:0] VIDEO_END = 20'hB8000;
  localparam logic [11:0] STATUS_PORT = 12'h3BA;

  localparam logic [DATA_W-1:0] VECTOR_WORD = 16'hFF08;
  localparam logic [DATA_W-1:0] OPEN_BUS = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ACK   = 2'd2,
    OP_LOAD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    SEL_RAM = 2'd0,
    SEL_VID = 2'd1,
    SEL_ROM = 2'd2
  } mem_sel_e;

  typedef struct packed {
    logic             en;
    logic             we;
    mem_sel_e         sel;
    logic [IDX_W-1:0] idx;
    logic [1:0]       be;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- sv/xbmt_mem.sv -----
module xbmt_mem (
  input  logic                          clk_i,
  input  xbmt_pkg::mem_req_t            req_i,
  output logic [xbmt_pkg::DATA_W-1:0]   rdata_o
);

  localparam int unsigned VID_WORDS = xbmt_pkg::VIDEO_BYTES / 2;
  localparam int unsigned ROM_WORDS = xbmt_pkg::ROM_BYTES / 2;

  logic [7:0] ram_lo [xbmt_pkg::RAM_WORDS];
  logic [7:0] ram_hi [xbmt_pkg::RAM_WORDS];
  logic [7:0] vid_lo [VID_WORDS];
  logic [7:0] vid_hi [VID_WORDS];
  logic [xbmt_pkg::DATA_W-1:0] rom [ROM_WORDS];

  logic [xbmt_pkg::RAM_IW-1:0] ram_idx;
  logic [xbmt_pkg::VID_IW-1:0] vid_idx;
  logic [xbmt_pkg::ROM_IW-1:0] rom_idx;

  logic [xbmt_pkg::DATA_W-1:0] ram_rd_q;
  logic [xbmt_pkg::DATA_W-1:0] vid_rd_q;
  logic [xbmt_pkg::DATA_W-1:0] rom_rd_q;
  xbmt_pkg::mem_sel_e          sel_q;

  assign ram_idx = req_i.idx[xbmt_pkg::RAM_IW-1:0];
  assign vid_idx = req_i.idx[xbmt_pkg::VID_IW-1:0];
  assign rom_idx = req_i.idx[xbmt_pkg::ROM_IW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.sel == xbmt_pkg::SEL_RAM) begin
      if (req_i.we) begin
        if (req_i.be[0]) ram_lo[ram_idx] <= req_i.wdata[7:0];
        if (req_i.be[1]) ram_hi[ram_idx] <= req_i.wdata[15:8];
      end
      ram_rd_q <= {ram_hi[ram_idx], ram_lo[ram_idx]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.sel == xbmt_pkg::SEL_VID) begin
      if (req_i.we) begin
        if (req_i.be[0]) vid_lo[vid_idx] <= req_i.wdata[7:0];
        if (req_i.be[1]) vid_hi[vid_idx] <= req_i.wdata[15:8];
      end
      vid_rd_q <= {vid_hi[vid_idx], vid_lo[vid_idx]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.sel == xbmt_pkg::SEL_ROM) begin
      if (req_i.we) begin
        rom[rom_idx] <= req_i.wdata;
      end
      rom_rd_q <= rom[rom_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      sel_q <= req_i.sel;
    end
  end

  always_comb begin
    case (sel_q)
      xbmt_pkg::SEL_RAM: rdata_o = ram_rd_q;
      xbmt_pkg::SEL_VID: rdata_o = vid_rd_q;
      xbmt_pkg::SEL_ROM: rdata_o = rom_rd_q;
      default:           rdata_o = xbmt_pkg::OPEN_BUS;
    endcase
  end

endmodule

// ----- sv/x86_bus_memory_target.sv -----
// Memory and I/O target for a 16-bit x86 bus.
// Input channel: one beat per decoded access (read, write, interrupt acknowledge,
// ROM load), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one beat per read or acknowledge, held on read_data_o and
// intr_release_o while out_valid_o is high and out_stall_i is high.
// Read path: the memories read at the edge that takes a read beat and the result is
// registered on the outputs at the next edge; an acknowledge result is on the
// outputs right after the edge that takes it. Writes and ROM loads give no beat.
// A read holds the block in its read state until the result is registered, as the
// memories have a registered read port; writes, loads and acknowledges do not.
// The input stalls while a read is in flight and whenever the output register
// holds a beat that the receiver is stalling.
// Reset clears the status port value, the pending vector flag and the output
// valid; memory contents are not cleared and read as undefined until written.
module x86_bus_memory_target (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [xbmt_pkg::ADDR_W-1:0]   address_i,
  input  logic                          is_memory_i,
  input  logic                          high_byte_disable_i,
  input  logic [xbmt_pkg::DATA_W-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [xbmt_pkg::DATA_W-1:0]   read_data_o,
  output logic                          intr_release_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic vec_pend_q, vec_pend_d;
  logic [3:0] status_q, status_d;
  logic use_mem_q, use_mem_d;
  logic [xbmt_pkg::DATA_W-1:0] fixed_q, fixed_d;
  logic out_valid_q, out_valid_d;
  logic [xbmt_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic out_rel_q, out_rel_d;

  logic in_acc;
  logic out_free;
  logic hit_ram, hit_rom, hit_vid, hit_status;
  logic [3:0] status_step;
  logic [xbmt_pkg::DATA_W-1:0] mem_rdata;
  xbmt_pkg::mem_req_t mem_req;
  xbmt_pkg::opcode_e op;

  assign op = xbmt_pkg::opcode_e'(opcode_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == S_READ) || !out_free;
  assign in_acc = in_valid_i && !in_stall_o;

  assign hit_ram = address_i < xbmt_pkg::RAM_LIMIT;
  assign hit_rom = address_i >= xbmt_pkg::ROM_BASE;
  assign hit_vid = (address_i >= xbmt_pkg::VIDEO_BASE) && (address_i < xbmt_pkg::VIDEO_END);
  assign hit_status = address_i[11:1] == xbmt_pkg::STATUS_PORT[11:1];

  always_comb begin
    status_step = status_q ^ 4'h1;
    if (!status_step[0]) status_step = status_step ^ 4'h8;
  end

  always_comb begin
    state_d = state_q;
    vec_pend_d = vec_pend_q;
    status_d = status_q;
    use_mem_d = use_mem_q;
    fixed_d = fixed_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d = out_data_q;
    out_rel_d = out_rel_q;
    mem_req = '0;
    mem_req.be = {!high_byte_disable_i, !address_i[0]};
    mem_req.wdata = write_data_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            xbmt_pkg::OP_READ: begin
              state_d = S_READ;
              use_mem_d = 1'b0;
              fixed_d = xbmt_pkg::OPEN_BUS;
              if (vec_pend_q) begin
                fixed_d = xbmt_pkg::VECTOR_WORD;
                vec_pend_d = 1'b0;
              end else if (is_memory_i) begin
                if (hit_ram) begin
                  use_mem_d = 1'b1;
                  mem_req.en = 1'b1;
                  mem_req.sel = xbmt_pkg::SEL_RAM;
                  mem_req.idx = xbmt_pkg::IDX_W'(address_i[xbmt_pkg::RAM_IW:1]);
                end else if (hit_rom) begin
                  use_mem_d = 1'b1;
                  mem_req.en = 1'b1;
                  mem_req.sel = xbmt_pkg::SEL_ROM;
                  mem_req.idx = xbmt_pkg::IDX_W'(address_i[xbmt_pkg::ROM_IW:1]);
                end else if (hit_vid) begin
                  use_mem_d = 1'b1;
                  mem_req.en = 1'b1;
                  mem_req.sel = xbmt_pkg::SEL_VID;
                  mem_req.idx = xbmt_pkg::IDX_W'(address_i[xbmt_pkg::VID_IW:1]);
                end
              end else if (hit_status) begin
                status_d = status_step;
                fixed_d = xbmt_pkg::DATA_W'(status_step);
              end
            end
            xbmt_pkg::OP_WRITE: begin
              if (is_memory_i && hit_ram) begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                mem_req.sel = xbmt_pkg::SEL_RAM;
                mem_req.idx = xbmt_pkg::IDX_W'(address_i[xbmt_pkg::RAM_IW:1]);
              end else if (is_memory_i && !hit_rom && hit_vid) begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                mem_req.sel = xbmt_pkg::SEL_VID;
                mem_req.idx = xbmt_pkg::IDX_W'(address_i[xbmt_pkg::VID_IW:1]);
              end
            end
            xbmt_pkg::OP_ACK: begin
              vec_pend_d = 1'b1;
              out_valid_d = 1'b1;
              out_data_d = '0;
              out_rel_d = 1'b1;
            end
            xbmt_pkg::OP_LOAD: begin
              if (address_i < xbmt_pkg::ROM_LIMIT) begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
                mem_req.sel = xbmt_pkg::SEL_ROM;
                mem_req.be = 2'b11;
                mem_req.idx = xbmt_pkg::IDX_W'(address_i[xbmt_pkg::ROM_IW:1]);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d = use_mem_q ? mem_rdata : fixed_q;
          out_rel_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  xbmt_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vec_pend_q <= 1'b0;
      status_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vec_pend_q <= vec_pend_d;
      status_q <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    use_mem_q <= use_mem_d;
    fixed_q <= fixed_d;
    out_data_q <= out_data_d;
    out_rel_q <= out_rel_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign intr_release_o = out_rel_q;

  a_read_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |->
      $past(state_q == S_READ) || $past(in_acc && op == xbmt_pkg::OP_READ))
    else $error("read state entered without a read beat");

  a_ack_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op == xbmt_pkg::OP_ACK |=> vec_pend_q && out_valid_q && out_rel_q)
    else $error("acknowledge did not set pending vector and result");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.en |-> state_q == S_IDLE && in_acc)
    else $error("memory access outside an accepted beat");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ && out_free |=> out_valid_q && !out_rel_q && state_q == S_IDLE)
    else $error("read result not delivered");

endmodule

// ----- sim/tb_x86_bus_memory_target.sv -----
`timescale 1ns / 100ps

module tb_x86_bus_memory_target;

  localparam int unsigned RANDOM_BEATS = 500;
  localparam int unsigned CALM_TAIL = 60;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned N_DIRECTED = 29;

  typedef struct packed {
    xbmt_pkg::opcode_e           op;
    logic [xbmt_pkg::ADDR_W-1:0] addr;
    logic                        is_mem;
    logic                        bhe;
    logic [xbmt_pkg::DATA_W-1:0] wdata;
  } access_t;

  typedef struct packed {
    logic [xbmt_pkg::DATA_W-1:0] data;
    logic                        intr_rel;
  } reply_t;

  typedef struct packed {
    access_t acc;
    logic    fixed;
    reply_t  want;
  } step_t;

  localparam reply_t NONE = '{16'h0000, 1'b0};
  localparam reply_t ACKED = '{16'h0000, 1'b1};
  localparam reply_t VEC_REPLY = '{xbmt_pkg::VECTOR_WORD, 1'b0};
  localparam reply_t OPEN_REPLY = '{xbmt_pkg::OPEN_BUS, 1'b0};

  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{'{xbmt_pkg::OP_READ,  20'h003BA, 1'b0, 1'b0, 16'h0000}, 1'b1, '{16'h0001, 1'b0}},
    '{'{xbmt_pkg::OP_READ,  20'hFF3BB, 1'b0, 1'b1, 16'hFFFF}, 1'b1, '{16'h0008, 1'b0}},
    '{'{xbmt_pkg::OP_READ,  20'h003BA, 1'b0, 1'b0, 16'h0000}, 1'b1, '{16'h0009, 1'b0}},
    '{'{xbmt_pkg::OP_READ,  20'h803BB, 1'b0, 1'b0, 16'h0000}, 1'b1, '{16'h0000, 1'b0}},
    '{'{xbmt_pkg::OP_READ,  20'h003B8, 1'b0, 1'b0, 16'h0000}, 1'b1, OPEN_REPLY},
    '{'{xbmt_pkg::OP_ACK,   20'h00000, 1'b1, 1'b0, 16'h0000}, 1'b1, ACKED},
    '{'{xbmt_pkg::OP_READ,  20'h003BA, 1'b0, 1'b0, 16'h0000}, 1'b1, VEC_REPLY},
    '{'{xbmt_pkg::OP_READ,  20'h003BA, 1'b0, 1'b0, 16'h0000}, 1'b1, '{16'h0001, 1'b0}},
    '{'{xbmt_pkg::OP_ACK,   20'hFFFFF, 1'b0, 1'b1, 16'hFFFF}, 1'b1, ACKED},
    '{'{xbmt_pkg::OP_READ,  20'h20000, 1'b1, 1'b0, 16'h0000}, 1'b1, VEC_REPLY},
    '{'{xbmt_pkg::OP_READ,  20'h20000, 1'b1, 1'b0, 16'h0000}, 1'b1, OPEN_REPLY},
    '{'{xbmt_pkg::OP_READ,  20'hB8000, 1'b1, 1'b0, 16'h0000}, 1'b1, OPEN_REPLY},
    '{'{xbmt_pkg::OP_WRITE, 20'h00000, 1'b1, 1'b0, 16'hA5C3}, 1'b0, NONE},
    // illegal lanes, then an I/O write: both must leave RAM alone
    '{'{xbmt_pkg::OP_WRITE, 20'h00001, 1'b1, 1'b1, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_WRITE, 20'h00000, 1'b0, 1'b0, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_READ,  20'h00001, 1'b1, 1'b0, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_WRITE, 20'h1FFFE, 1'b1, 1'b0, 16'hFFFF}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_WRITE, 20'h1FFFF, 1'b1, 1'b0, 16'h12EE}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_READ,  20'h1FFFF, 1'b1, 1'b1, 16'h0000}, 1'b0, NONE},
    // video mirror at both ends of the window
    '{'{xbmt_pkg::OP_WRITE, 20'hB0000, 1'b1, 1'b0, 16'hBEEF}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_WRITE, 20'hB7FFE, 1'b1, 1'b0, 16'h5A5A}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_READ,  20'hB7001, 1'b1, 1'b0, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_READ,  20'hB0FFF, 1'b1, 1'b0, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_LOAD,  20'h00000, 1'b1, 1'b0, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_LOAD,  20'h01FFF, 1'b0, 1'b1, 16'hFFFF}, 1'b0, NONE},
    // load past the ROM and a bus write into the ROM area are dropped
    '{'{xbmt_pkg::OP_LOAD,  20'h02000, 1'b1, 1'b0, 16'h1111}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_WRITE, 20'hFE000, 1'b1, 1'b0, 16'h7777}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_READ,  20'hFE001, 1'b1, 1'b0, 16'h0000}, 1'b0, NONE},
    '{'{xbmt_pkg::OP_READ,  20'hFFFFE, 1'b1, 1'b0, 16'h0000}, 1'b0, NONE}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [1:0]                  opcode_i;
  logic [xbmt_pkg::ADDR_W-1:0] address_i;
  logic                        is_memory_i;
  logic                        high_byte_disable_i;
  logic [xbmt_pkg::DATA_W-1:0] write_data_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [xbmt_pkg::DATA_W-1:0] read_data_o;
  logic                        intr_release_o;

  x86_bus_memory_target dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .address_i          (address_i),
    .is_memory_i        (is_memory_i),
    .high_byte_disable_i(high_byte_disable_i),
    .write_data_i       (write_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_data_o        (read_data_o),
    .intr_release_o     (intr_release_o)
  );

  // shadow of the target
  logic [7:0]                  ram_img [xbmt_pkg::RAM_BYTES];
  bit                          ram_ok  [xbmt_pkg::RAM_BYTES];
  logic [7:0]                  vid_img [xbmt_pkg::VIDEO_BYTES];
  bit                          vid_ok  [xbmt_pkg::VIDEO_BYTES];
  logic [xbmt_pkg::DATA_W-1:0] rom_img [xbmt_pkg::ROM_BYTES/2];
  bit                          rom_ok  [xbmt_pkg::ROM_BYTES/2];
  logic [3:0]                  status_val;
  bit                          vector_armed;

  // fully written words, the only RAM, video and ROM words a read may target
  int unsigned ram_words [$];
  int unsigned vid_words [$];
  int unsigned rom_words [$];

  reply_t      replies_due [$];
  int unsigned op_count [4];
  int unsigned replies_seen;
  int unsigned errors;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void store_byte(input bit to_video, input int unsigned idx,
                                     input logic [7:0] v);
    int unsigned w;
    bit          was_full;
    w = idx & ~32'd1;
    if (to_video) begin
      was_full = vid_ok[w] && vid_ok[w+1];
      vid_img[idx] = v;
      vid_ok[idx] = 1'b1;
      if (!was_full && vid_ok[w] && vid_ok[w+1]) vid_words.push_back(w);
    end else begin
      was_full = ram_ok[w] && ram_ok[w+1];
      ram_img[idx] = v;
      ram_ok[idx] = 1'b1;
      if (!was_full && ram_ok[w] && ram_ok[w+1]) ram_words.push_back(w);
    end
  endfunction

  // applies one access to the shadow; returns 1 when it produces a reply
  function automatic bit serve_access(input access_t a, output reply_t r);
    int unsigned base;
    bit          to_video;
    bit          hit;
    r = NONE;
    case (a.op)
      xbmt_pkg::OP_READ: begin
        if (vector_armed) begin
          vector_armed = 1'b0;
          r.data = xbmt_pkg::VECTOR_WORD;
        end else if (a.is_mem) begin
          if (a.addr < xbmt_pkg::RAM_LIMIT) begin
            base = {a.addr[xbmt_pkg::ADDR_W-1:1], 1'b0};
            r.data = {ram_img[base+1], ram_img[base]};
          end else if (a.addr >= xbmt_pkg::ROM_BASE) begin
            r.data = rom_img[(a.addr - xbmt_pkg::ROM_BASE) >> 1];
          end else if (a.addr >= xbmt_pkg::VIDEO_BASE && a.addr < xbmt_pkg::VIDEO_END) begin
            base = ((a.addr - xbmt_pkg::VIDEO_BASE) & ~32'd1) % xbmt_pkg::VIDEO_BYTES;
            r.data = {vid_img[base+1], vid_img[base]};
          end else begin
            r.data = xbmt_pkg::OPEN_BUS;
          end
        end else if (a.addr[11:1] == xbmt_pkg::STATUS_PORT[11:1]) begin
          status_val = status_val ^ 4'd1;
          if (!status_val[0]) status_val = status_val ^ 4'd8;
          r.data = xbmt_pkg::DATA_W'(status_val);
        end else begin
          r.data = xbmt_pkg::OPEN_BUS;
        end
        return 1'b1;
      end
      xbmt_pkg::OP_WRITE: begin
        hit = 1'b0;
        to_video = 1'b0;
        base = 0;
        if (a.is_mem && a.addr < xbmt_pkg::RAM_LIMIT) begin
          base = a.addr;
          hit = 1'b1;
        end else if (a.is_mem && a.addr >= xbmt_pkg::VIDEO_BASE
                     && a.addr < xbmt_pkg::VIDEO_END) begin
          base = (a.addr - xbmt_pkg::VIDEO_BASE) % xbmt_pkg::VIDEO_BYTES;
          to_video = 1'b1;
          hit = 1'b1;
        end
        if (hit) begin
          if (!a.addr[0]) begin
            store_byte(to_video, base, a.wdata[7:0]);
            if (!a.bhe) store_byte(to_video, base + 1, a.wdata[15:8]);
          end else if (!a.bhe) begin
            store_byte(to_video, base, a.wdata[15:8]);
          end
        end
        return 1'b0;
      end
      xbmt_pkg::OP_ACK: begin
        vector_armed = 1'b1;
        r = ACKED;
        return 1'b1;
      end
      xbmt_pkg::OP_LOAD: begin
        if (a.addr < xbmt_pkg::ROM_LIMIT) begin
          base = a.addr >> 1;
          rom_img[base] = a.wdata;
          if (!rom_ok[base]) begin
            rom_ok[base] = 1'b1;
            rom_words.push_back(base);
          end
        end
        return 1'b0;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [xbmt_pkg::ADDR_W-1:0] unmapped_addr();
    if ($urandom_range(0, 1)) begin
      return xbmt_pkg::ADDR_W'($urandom_range(xbmt_pkg::RAM_BYTES, 32'hAFFFF));
    end
    return xbmt_pkg::ADDR_W'($urandom_range(32'hB8000, 32'(xbmt_pkg::ROM_BASE) - 1));
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    a.op = xbmt_pkg::OP_READ;
    a.addr = xbmt_pkg::ADDR_W'($urandom);
    a.is_mem = 1'b1;
    a.bhe = 1'($urandom);
    a.wdata = xbmt_pkg::DATA_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      a.op = xbmt_pkg::OP_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        a.addr = xbmt_pkg::ADDR_W'($urandom_range(0, 255));
      end else if (pick < 40) begin
        a.addr = xbmt_pkg::RAM_LIMIT - xbmt_pkg::ADDR_W'($urandom_range(1, 256));
      end else if (pick < 55) begin
        a.addr = xbmt_pkg::ADDR_W'($urandom_range(0, xbmt_pkg::RAM_BYTES - 1));
      end else if (pick < 80) begin
        a.addr = xbmt_pkg::VIDEO_BASE + xbmt_pkg::ADDR_W'($urandom_range(0, 32'h7FFF));
      end else if (pick < 87) begin
        a.addr = xbmt_pkg::ROM_BASE
               + xbmt_pkg::ADDR_W'($urandom_range(0, xbmt_pkg::ROM_BYTES - 1));
      end else if (pick < 93) begin
        a.addr = unmapped_addr();
      end else begin
        a.is_mem = 1'b0;
      end
    end else if (pick < 42) begin
      a.op = xbmt_pkg::OP_LOAD;
      a.is_mem = 1'($urandom);
      if ($urandom_range(0, 6) != 0) begin
        a.addr = xbmt_pkg::ADDR_W'($urandom_range(0, xbmt_pkg::ROM_BYTES - 1));
      end
    end else if (pick < 49) begin
      a.op = xbmt_pkg::OP_ACK;
      a.is_mem = 1'($urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && ram_words.size() != 0) begin
        a.addr = xbmt_pkg::ADDR_W'(ram_words[$urandom_range(0, ram_words.size() - 1)])
               | xbmt_pkg::ADDR_W'($urandom_range(0, 1));
      end else if (pick < 50 && vid_words.size() != 0) begin
        a.addr = xbmt_pkg::VIDEO_BASE
               + xbmt_pkg::ADDR_W'($urandom_range(0, 7) * xbmt_pkg::VIDEO_BYTES)
               + xbmt_pkg::ADDR_W'(vid_words[$urandom_range(0, vid_words.size() - 1)])
               + xbmt_pkg::ADDR_W'($urandom_range(0, 1));
      end else if (pick < 65 && rom_words.size() != 0) begin
        a.addr = xbmt_pkg::ROM_BASE
               + xbmt_pkg::ADDR_W'(2 * rom_words[$urandom_range(0, rom_words.size() - 1)])
               + xbmt_pkg::ADDR_W'($urandom_range(0, 1));
      end else if (pick < 80) begin
        a.is_mem = 1'b0;
        a.addr = (a.addr & 20'hFF001) | xbmt_pkg::ADDR_W'(xbmt_pkg::STATUS_PORT);
      end else if (pick < 88) begin
        a.is_mem = 1'b0;
      end else begin
        a.addr = unmapped_addr();
      end
    end
    return a;
  endfunction

  task automatic offer_beat(input access_t a, input bit fixed, input reply_t want);
    reply_t got;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= a.op;
    address_i <= a.addr;
    is_memory_i <= a.is_mem;
    high_byte_disable_i <= a.bhe;
    write_data_i <= a.wdata;
    do @(posedge clk_i); while (in_stall_o);
    if (serve_access(a, got)) replies_due.push_back(fixed ? want : got);
    op_count[a.op]++;
  endtask

  // receiver
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: reply with none expected: read_data %h intr_release %b",
                 $time, read_data_o, intr_release_o);
      end else begin
        due = replies_due.pop_front();
        if (read_data_o !== due.data) begin
          errors++;
          $display("%0t: read_data expected %h actual %h", $time, due.data, read_data_o);
        end
        if (intr_release_o !== due.intr_rel) begin
          errors++;
          $display("%0t: intr_release expected %b actual %b",
                   $time, due.intr_rel, intr_release_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d replies outstanding",
               $time, QUIET_LIMIT, replies_due.size());
      $display("[x86_bus_memory_target] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = xbmt_pkg::OP_READ;
    address_i = '0;
    is_memory_i = 1'b0;
    high_byte_disable_i = 1'b0;
    write_data_i = '0;
    status_val = 4'd0;
    vector_armed = 1'b0;
    replies_seen = 0;
    errors = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < N_DIRECTED; i++)
      offer_beat(DIRECTED[i].acc, DIRECTED[i].fixed, DIRECTED[i].want);
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      // idle-free stretches every third block of 40, none at all in the tail
      idle_on = (k < RANDOM_BEATS - CALM_TAIL) && ((k / 40) % 3 != 2);
      if (k == 120 || k == 330) long_hold_req = 1'b1;
      offer_beat(random_access(), 1'b0, NONE);
    end
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Ran %0d reads, %0d writes, %0d acknowledges and %0d ROM loads over RAM, video,",
             op_count[xbmt_pkg::OP_READ], op_count[xbmt_pkg::OP_WRITE],
             op_count[xbmt_pkg::OP_ACK], op_count[xbmt_pkg::OP_LOAD]);
    $display("ROM, status port and open bus with two long output holds; %0d replies checked.",
             replies_seen);
    if (errors == 0) begin
      $display("[x86_bus_memory_target] OK");
    end else begin
      $display("[x86_bus_memory_target] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/xbmt_pkg.sv
sv/xbmt_mem.sv
sv/x86_bus_memory_target.sv
sim/tb_x86_bus_memory_target.sv
